@@ rtl/core/usw_pkg.sv @@
// ----------------------------------------------------------------------------
// usw_pkg
// Shared sizes, status codes and op codes of the urn sampler.
// ----------------------------------------------------------------------------
package usw_pkg;

    localparam int NUM_SLOTS   = 64;
    localparam int COUNT_WIDTH = 32;
    localparam int TOTAL_WIDTH = 38;
    localparam int SLOT_WIDTH  = 6;
    localparam int LOAD_WIDTH  = 32;
    localparam int ADDR_WIDTH  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DRAW = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DRAW_OK   = 2'd0,
        ST_LOAD_DONE = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

endpackage

@@ rtl/core/usw_ram.sv @@
// ----------------------------------------------------------------------------
// usw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module usw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/urn_sampler_without_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// urn_sampler_without_replacement_unit
// Load: result registered from S_LOAD. Draw that hits slot k: S_SCAN walks
// slots 0 to k; empty table or index out of range: result valid in the cycle
// after accept. One item at a time; the walk is paced by the single read
// port of the count RAM, which it walks one slot per cycle.
// Reset clears the total and the per-slot valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module urn_sampler_without_replacement_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [usw_pkg::SLOT_WIDTH-1:0]      s_slot,
    input  logic [usw_pkg::LOAD_WIDTH-1:0]      s_load_count,
    input  logic [usw_pkg::TOTAL_WIDTH-1:0]     s_rand_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [usw_pkg::SLOT_WIDTH-1:0]      m_chosen_slot,
    output usw_pkg::status_t                    m_status,
    output logic [usw_pkg::TOTAL_WIDTH-1:0]     m_total_left
);

    import usw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN
    } state_t;

    state_t                   state_reg, state_next;
    logic [NUM_SLOTS-1:0]     valid_reg, valid_next;
    logic                     vld_rd_reg;
    logic [TOTAL_WIDTH-1:0]   total_reg, total_next;
    logic [TOTAL_WIDTH-1:0]   idx_reg, idx_next;
    logic [ADDR_WIDTH-1:0]    scan_idx_reg, scan_idx_next;
    logic [ADDR_WIDTH-1:0]    slot_reg, slot_next;
    logic [COUNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                     m_valid_reg, m_valid_next;
    logic [SLOT_WIDTH-1:0]    chosen_reg, chosen_next;
    status_t                  status_reg, status_next;
    logic [TOTAL_WIDTH-1:0]   total_left_reg, total_left_next;

    logic                     wr_en;
    logic [ADDR_WIDTH-1:0]    wr_addr;
    logic [COUNT_WIDTH-1:0]   wr_data;
    logic [ADDR_WIDTH-1:0]    rd_addr;
    logic [COUNT_WIDTH-1:0]   rd_data;

    logic [COUNT_WIDTH-1:0]   count_cur;
    logic [TOTAL_WIDTH:0]     diff;
    logic                     hit;
    logic                     last;
    logic                     out_free;
    logic                     accept;
    logic [TOTAL_WIDTH-1:0]   load_total;

    usw_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_SLOTS)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign count_cur  = vld_rd_reg ? rd_data : '0;
    assign diff       = {1'b0, idx_reg}
                      - {{(TOTAL_WIDTH + 1 - COUNT_WIDTH){1'b0}}, count_cur};
    assign hit        = diff[TOTAL_WIDTH];
    assign last       = (scan_idx_reg == ADDR_WIDTH'(NUM_SLOTS - 1));
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == S_IDLE) && out_free;
    assign accept     = s_valid && s_ready;
    assign load_total = total_reg
                      - {{(TOTAL_WIDTH - COUNT_WIDTH){1'b0}}, count_cur}
                      + {{(TOTAL_WIDTH - COUNT_WIDTH){1'b0}}, cnt_reg};

    assign m_valid       = m_valid_reg;
    assign m_chosen_slot = chosen_reg;
    assign m_status      = status_reg;
    assign m_total_left  = total_left_reg;

    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        scan_idx_next   = scan_idx_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        chosen_next     = chosen_reg;
        status_next     = status_reg;
        total_left_next = total_left_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = cnt_reg;
        rd_addr         = scan_idx_reg;

        case (state_reg)
            S_IDLE: begin
                rd_addr = (op_t'(s_op) == OP_DRAW) ? '0 : ADDR_WIDTH'(s_slot);
                if (accept) begin
                    if (op_t'(s_op) == OP_LOAD) begin
                        slot_next = ADDR_WIDTH'(s_slot);
                        cnt_next  = COUNT_WIDTH'(s_load_count);
                        if (int'(s_slot) < NUM_SLOTS) begin
                            state_next = S_LOAD;
                        end else begin
                            m_valid_next    = 1'b1;
                            chosen_next     = '0;
                            status_next     = ST_LOAD_DONE;
                            total_left_next = total_reg;
                        end
                    end else begin
                        idx_next      = s_rand_index;
                        scan_idx_next = '0;
                        if (total_reg == '0) begin
                            m_valid_next    = 1'b1;
                            chosen_next     = '0;
                            status_next     = ST_EMPTY;
                            total_left_next = total_reg;
                        end else if (s_rand_index >= total_reg) begin
                            m_valid_next    = 1'b1;
                            chosen_next     = '0;
                            status_next     = ST_RANGE;
                            total_left_next = total_reg;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_LOAD: begin
                rd_addr = slot_reg;
                if (out_free) begin
                    wr_en                = 1'b1;
                    wr_addr              = slot_reg;
                    wr_data              = cnt_reg;
                    valid_next[slot_reg] = 1'b1;
                    total_next           = load_total;
                    m_valid_next         = 1'b1;
                    chosen_next          = '0;
                    status_next          = ST_LOAD_DONE;
                    total_left_next      = load_total;
                    state_next           = S_IDLE;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    if (out_free) begin
                        wr_en                    = 1'b1;
                        wr_addr                  = scan_idx_reg;
                        wr_data                  = count_cur - COUNT_WIDTH'(1);
                        valid_next[scan_idx_reg] = 1'b1;
                        total_next               = total_reg - TOTAL_WIDTH'(1);
                        m_valid_next             = 1'b1;
                        chosen_next              = SLOT_WIDTH'(scan_idx_reg);
                        status_next              = ST_DRAW_OK;
                        total_left_next          = total_reg - TOTAL_WIDTH'(1);
                        state_next               = S_IDLE;
                    end
                end else if (last) begin
                    if (out_free) begin
                        m_valid_next    = 1'b1;
                        chosen_next     = '0;
                        status_next     = ST_RANGE;
                        total_left_next = total_reg;
                        state_next      = S_IDLE;
                    end
                end else begin
                    idx_next      = diff[TOTAL_WIDTH-1:0];
                    scan_idx_next = scan_idx_reg + ADDR_WIDTH'(1);
                    rd_addr       = scan_idx_reg + ADDR_WIDTH'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        vld_rd_reg     <= valid_reg[rd_addr];
        idx_reg        <= idx_next;
        scan_idx_reg   <= scan_idx_next;
        slot_reg       <= slot_next;
        cnt_reg        <= cnt_next;
        chosen_reg     <= chosen_next;
        status_reg     <= status_next;
        total_left_reg <= total_left_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ rtl/core/usw_checker.sv @@
// ----------------------------------------------------------------------------
// usw_checker
// Port-level checks on the urn sampler, bound to the top level.
// ----------------------------------------------------------------------------
module usw_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [usw_pkg::SLOT_WIDTH-1:0]      m_chosen_slot,
    input  usw_pkg::status_t                    m_status,
    input  logic [usw_pkg::TOTAL_WIDTH-1:0]     m_total_left
);

    import usw_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chosen_slot)
            && $stable(m_status) && $stable(m_total_left))
        else $error("stalled result item changed");

    a_slot_zero_on_non_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_DRAW_OK |-> m_chosen_slot == '0)
        else $error("chosen slot nonzero on a non-draw result");

    a_empty_means_zero_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_total_left == '0)
        else $error("empty status with nonzero total");

    // one item at a time: after an accept the block is busy or holds a result
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready || m_valid)
        else $error("input ready again with no result pending");

endmodule

bind urn_sampler_without_replacement_unit usw_checker u_usw_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_chosen_slot (m_chosen_slot),
    .m_status      (m_status),
    .m_total_left  (m_total_left)
);

@@ tb/sv/urn_sampler_checker.sv @@
// ----------------------------------------------------------------------------
// urn_sampler_checker
// Watches both channels of the urn sampler. Keeps its own slot count table
// and running total, predicts the result of every accepted item, and
// compares each accepted result field by field against the oldest
// prediction. Exports the failure count, the results still owed and the
// current predicted total.
// ----------------------------------------------------------------------------
module urn_sampler_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_op,
    input  logic [usw_pkg::SLOT_WIDTH-1:0]   s_slot,
    input  logic [usw_pkg::LOAD_WIDTH-1:0]   s_load_count,
    input  logic [usw_pkg::TOTAL_WIDTH-1:0]  s_rand_index,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [usw_pkg::SLOT_WIDTH-1:0]   m_chosen_slot,
    input  usw_pkg::status_t                 m_status,
    input  logic [usw_pkg::TOTAL_WIDTH-1:0]  m_total_left,
    output int                               fail_count,
    output int                               results_owed,
    output logic [usw_pkg::TOTAL_WIDTH-1:0]  urn_total
);
    timeunit 1ns;
    timeprecision 1ps;

    import usw_pkg::*;

    typedef struct packed {
        logic [SLOT_WIDTH-1:0]  slot;
        status_t                status;
        logic [TOTAL_WIDTH-1:0] total;
    } urn_result_t;

    logic [COUNT_WIDTH-1:0] slot_left [NUM_SLOTS];
    logic [TOTAL_WIDTH-1:0] total_left;
    urn_result_t            owed_q [$];
    int                     errors = 0;

    assign fail_count = errors;

    function automatic urn_result_t apply_item(input op_t op,
                                               input logic [SLOT_WIDTH-1:0] slot,
                                               input logic [LOAD_WIDTH-1:0] cnt,
                                               input logic [TOTAL_WIDTH-1:0] idx);
        urn_result_t            r;
        logic [TOTAL_WIDTH-1:0] rest;
        r.slot   = '0;
        r.status = ST_RANGE;
        if (op == OP_LOAD) begin
            if (int'(slot) < NUM_SLOTS) begin
                total_left = total_left - TOTAL_WIDTH'(slot_left[slot])
                           + TOTAL_WIDTH'(cnt[COUNT_WIDTH-1:0]);
                slot_left[slot] = cnt[COUNT_WIDTH-1:0];
            end
            r.status = ST_LOAD_DONE;
        end else if (total_left == '0) begin
            r.status = ST_EMPTY;
        end else if (idx < total_left) begin
            rest = idx;
            for (int n = 0; n < NUM_SLOTS; n++) begin
                if (rest < TOTAL_WIDTH'(slot_left[n])) begin
                    slot_left[n] = slot_left[n] - 1'b1;
                    total_left   = total_left - 1'b1;
                    r.slot       = SLOT_WIDTH'(n);
                    r.status     = ST_DRAW_OK;
                    break;
                end
                rest = rest - TOTAL_WIDTH'(slot_left[n]);
            end
        end
        r.total = total_left;
        return r;
    endfunction

    always @(posedge aclk) begin
        urn_result_t want;
        urn_result_t got;
        if (!aresetn) begin
            for (int n = 0; n < NUM_SLOTS; n++) slot_left[n] = '0;
            total_left = '0;
            owed_q.delete();
        end else begin
            // retire the result first: it always belongs to an older item
            if (m_valid && m_ready) begin
                got = {m_chosen_slot, m_status, m_total_left};
                if (owed_q.size() == 0) begin
                    $error("unexpected result: chosen_slot %0d status %0d total_left %0d",
                           got.slot, got.status, got.total);
                    errors++;
                end else begin
                    want = owed_q.pop_front();
                    if (got.slot !== want.slot) begin
                        $error("chosen_slot: expected %0d, got %0d", want.slot, got.slot);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.total !== want.total) begin
                        $error("total_left: expected %0d, got %0d", want.total, got.total);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                owed_q = {owed_q,
                          apply_item(op_t'(s_op), s_slot, s_load_count, s_rand_index)};
        end
        results_owed <= owed_q.size();
        urn_total    <= total_left;
    end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the urn sampler. A directed opening covers the
// empty table, out of range indices, the first and last slot, empty slots
// skipped by the walk and count overwrites. Random episodes then fill the
// table and draw it down, run full-width tables, clear it and mix in noise,
// with bursty input and a stalling receiver that once holds off for long.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import usw_pkg::*;

    localparam int ITEM_TARGET  = 1700;
    localparam int GAP_MAX      = 16;
    localparam int LONG_HOLD    = 600;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = NUM_SLOTS + 8;
    localparam int DRAW_CAP     = 48;

    typedef enum int {FLOW, LIGHT, HEAVY, CHOKE} stall_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_op = 1'b0;
    logic [SLOT_WIDTH-1:0]  s_slot = '0;
    logic [LOAD_WIDTH-1:0]  s_load_count = '0;
    logic [TOTAL_WIDTH-1:0] s_rand_index = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [SLOT_WIDTH-1:0]  m_chosen_slot;
    status_t                m_status;
    logic [TOTAL_WIDTH-1:0] m_total_left;

    int                     fail_count;
    int                     results_owed;
    logic [TOTAL_WIDTH-1:0] urn_total;

    int items_sent = 0;
    int burst_left = 0;
    int accepted_items = 0;
    int quiet_cycles = 0;

    always #4 aclk = ~aclk;

    urn_sampler_without_replacement_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_slot        (s_slot),
        .s_load_count  (s_load_count),
        .s_rand_index  (s_rand_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_chosen_slot (m_chosen_slot),
        .m_status      (m_status),
        .m_total_left  (m_total_left)
    );

    urn_sampler_checker audit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_slot        (s_slot),
        .s_load_count  (s_load_count),
        .s_rand_index  (s_rand_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_chosen_slot (m_chosen_slot),
        .m_status      (m_status),
        .m_total_left  (m_total_left),
        .fail_count    (fail_count),
        .results_owed  (results_owed),
        .urn_total     (urn_total)
    );

    always @(posedge aclk) begin
        if (s_valid && s_ready) accepted_items <= accepted_items + 1;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("urn_sampler_without_replacement_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: segments of random stall density, one long hold-off
    initial begin
        stall_mode_t mode;
        int          span;
        bit          held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && accepted_items >= 400) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(10, 80);
            repeat (span) begin
                case (mode)
                    FLOW:    m_ready <= 1'b1;
                    LIGHT:   m_ready <= ($urandom_range(0, 3) != 0);
                    HEAVY:   m_ready <= ($urandom_range(0, 1) != 0);
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    task automatic offer(input op_t op, input logic [SLOT_WIDTH-1:0] slot,
                         input logic [LOAD_WIDTH-1:0] cnt,
                         input logic [TOTAL_WIDTH-1:0] idx);
        s_valid      <= 1'b1;
        s_op         <= op;
        s_slot       <= slot;
        s_load_count <= cnt;
        s_rand_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, GAP_MAX);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    function automatic logic [TOTAL_WIDTH-1:0] pick_index();
        logic [63:0] r;
        int          roll;
        r    = {$urandom(), $urandom()};
        roll = $urandom_range(0, 19);
        if (urn_total == '0 || roll == 0) return r[TOTAL_WIDTH-1:0];
        if (roll == 1) return '0;
        if (roll == 2) return urn_total - 1'b1;
        if (roll == 3) return urn_total;
        return TOTAL_WIDTH'(r % urn_total);
    endfunction

    task automatic draw_some(input int n);
        repeat (n) begin
            offer(OP_DRAW, SLOT_WIDTH'($urandom()), $urandom(), pick_index());
            pace();
        end
    endtask

    task automatic load_all(input bit big);
        logic [LOAD_WIDTH-1:0] cnt;
        for (int n = 0; n < NUM_SLOTS; n++) begin
            cnt = '0;
            if (big) cnt = ($urandom_range(0, 1) != 0) ? '1 : LOAD_WIDTH'($urandom());
            offer(OP_LOAD, SLOT_WIDTH'(n), cnt, TOTAL_WIDTH'({$urandom(), $urandom()}));
            pace();
        end
    endtask

    initial begin
        int episode;
        int roll;
        int n;
        logic [LOAD_WIDTH-1:0] cnt;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, then loads of zero and extreme counts
        offer(OP_DRAW, '0, '0, '0);                    settle();
        offer(OP_DRAW, '1, '1, '1);                    settle();
        offer(OP_LOAD, 6'd0, '0, '1);                  settle();
        offer(OP_DRAW, '0, '0, '0);                    settle();
        offer(OP_LOAD, 6'd63, '1, '0);                 settle();
        offer(OP_LOAD, 6'd0, 32'd1, '0);               settle();
        offer(OP_LOAD, 6'd31, 32'hAAAA_AAAA, '1);      settle();
        // index equal to total and far above it
        offer(OP_DRAW, '0, '0, urn_total);             settle();
        offer(OP_DRAW, '0, '0, '1);                    settle();
        // first slot, a middle slot, the last slot
        offer(OP_DRAW, '1, '1, '0);                    settle();
        offer(OP_DRAW, '0, '0, '0);                    settle();
        offer(OP_DRAW, '0, '0, urn_total - 1'b1);      settle();
        // overwrite down to an empty table
        offer(OP_LOAD, 6'd31, '0, '0);                 settle();
        offer(OP_LOAD, 6'd63, '0, '0);                 settle();
        offer(OP_DRAW, '0, '0, '0);                    settle();
        // walk skips an empty slot
        offer(OP_LOAD, 6'd5, 32'd3, '0);               settle();
        offer(OP_LOAD, 6'd6, 32'd0, '0);               settle();
        offer(OP_LOAD, 6'd7, 32'd2, '0);               settle();
        offer(OP_DRAW, '0, '0, 38'd3);                 settle();
        offer(OP_DRAW, '0, '0, 38'd4);                 settle();
        offer(OP_LOAD, 6'd5, 32'd1, '0);               settle();
        offer(OP_DRAW, '0, '0, 38'd1);                 settle();

        episode = 0;
        while (items_sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (episode == 0 || roll < 4) begin
                load_all(1'b1);
                draw_some(24);
                load_all(1'b0);
            end else if (roll < 14) begin
                load_all(1'b0);
            end else if (roll < 26) begin
                repeat ($urandom_range(4, 12)) begin
                    offer(op_t'($urandom_range(0, 1)), SLOT_WIDTH'($urandom()), $urandom(),
                          TOTAL_WIDTH'({$urandom(), $urandom()}));
                    pace();
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    roll = $urandom_range(0, 9);
                    if (roll < 7)      cnt = LOAD_WIDTH'($urandom_range(0, 6));
                    else if (roll < 9) cnt = LOAD_WIDTH'($urandom_range(0, 40));
                    else               cnt = LOAD_WIDTH'($urandom());
                    offer(OP_LOAD, SLOT_WIDTH'($urandom()), cnt,
                          TOTAL_WIDTH'({$urandom(), $urandom()}));
                    pace();
                end
                n = (urn_total > DRAW_CAP) ? DRAW_CAP : int'(urn_total);
                draw_some(n + $urandom_range(0, 3));
            end
            episode++;
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("urn_sampler_without_replacement_unit verification clean");
        else
            $display("urn_sampler_without_replacement_unit verification failed");
        $finish;
    end

endmodule

@@ urn_sampler_without_replacement_unit.f @@
rtl/core/usw_pkg.sv
rtl/core/usw_ram.sv
rtl/core/urn_sampler_without_replacement_unit.sv
rtl/core/usw_checker.sv
tb/sv/urn_sampler_checker.sv
tb/sv/testbench.sv
